@@ hdl/tga_rle_pixel_decoder_defines.svh @@
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder assertion macros
// Concurrent checks that compile away when ASSERT_OFF is defined.
// ---------------------------------------------------------------------------
`ifndef TGA_RLE_PIXEL_DECODER_DEFINES_SVH
`define TGA_RLE_PIXEL_DECODER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

@@ hdl/tgarle_pkg.sv @@
// ---------------------------------------------------------------------------
// TGA RLE decoder package
// Request modes, result status codes, register indexes and fixed widths.
// ---------------------------------------------------------------------------
package tgarle_pkg;

  localparam int TOTAL_W   = 31;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [1:0] {
    MODE_STREAM  = 2'd0,
    MODE_PALETTE = 2'd1,
    MODE_START   = 2'd2,
    MODE_NONE    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_PIXELS   = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_TOTAL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PALETTE_EXPAND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_CHANNELS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SWAP_RED_BLUE   = 3'd4;

  localparam logic [7:0] RUN_FLAG   = 8'd128;
  localparam logic [7:0] RUN_OFFSET = 8'd127;

  // swap bytes 0 and 2 of a pixel word
  function automatic logic [31:0] swap02(input logic [31:0] v);
    swap02 = {v[31:24], v[7:0], v[15:8], v[23:16]};
  endfunction

endpackage

@@ hdl/tgarle_ram.sv @@
// ---------------------------------------------------------------------------
// TGA RLE decoder generic RAM
// One write port, one read port with read enable and registered read data.
// ---------------------------------------------------------------------------
module tgarle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hdl/tga_rle_pixel_decoder.sv @@
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder
// Decodes run-length packets of a compressed pixel stream into pixel/run
// results, with optional palette expansion through an on-chip palette RAM.
// ---------------------------------------------------------------------------
// Takes one request per clock, back to back: stream bytes, palette writes and
// image starts. Each request is parsed in the cycle it is accepted; a pixel or
// run that completes is loaded into a single output register, so the result
// appears in the cycle after its last byte. Palette lookups read the palette
// RAM in that same accept cycle and its registered read data lands exactly in
// the output stage. in_ready drops only while a result waits in the output
// register and out_ready is low. The palette has no clearing pass; an entry
// that was never written reads as whatever the RAM holds.
`include "tga_rle_pixel_decoder_defines.svh"

module tga_rle_pixel_decoder #(
  parameter int PALETTE_DEPTH = 256,
  parameter int COUNT_BITS    = 30
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_stream_byte,
  input  logic [7:0]  in_palette_index,
  input  logic [31:0] in_palette_word,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_pixel_value,
  output logic [7:0]  out_repeat_count,
  output logic [1:0]  out_status
);

  localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CNT_W = COUNT_BITS + 1;
  localparam int SUM_W = ((CNT_W > tgarle_pkg::TOTAL_W) ? CNT_W : tgarle_pkg::TOTAL_W) + 1;

  typedef enum logic [1:0] {PH_HEADER, PH_LITERAL, PH_RUN} phase_t;

  // configuration
  logic [2:0]                     bpp_r;
  logic [tgarle_pkg::TOTAL_W-1:0] total_r;
  logic                           pal_en_r;
  logic [2:0]                     out_ch_r;
  logic                           swap_r;

  // parser state
  phase_t            phase_r, phase_nxt;
  logic [7:0]        packet_left_r, packet_left_nxt;
  logic [1:0]        bip_r, bip_nxt;
  logic [31:0]       gather_r, gather_nxt;
  logic [CNT_W-1:0]  done_r, done_nxt;
  logic              halted_r, halted_nxt;

  // output stage
  logic              out_valid_r, out_valid_nxt;
  logic [31:0]       value_r;
  logic [7:0]        count_r;
  tgarle_pkg::status_t status_r;
  logic              pal_sel_r, pal_oob_r, pal_keep4_r;

  logic              accept;
  logic              emit;
  logic [31:0]       res_value;
  logic [7:0]        res_count;
  tgarle_pkg::status_t res_status;
  logic              res_pal;
  logic              res_oob;

  logic [2:0]        width;
  logic [31:0]       gather_new;
  logic [31:0]       direct_val;
  logic [7:0]        count_c;
  logic [SUM_W-1:0]  total_sat;
  logic [SUM_W-1:0]  sum;
  logic [31:0]       ram_rdata;
  logic              ram_we;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpp_r    <= 3'd3;
      total_r  <= tgarle_pkg::TOTAL_W'(1);
      pal_en_r <= 1'b0;
      out_ch_r <= 3'd3;
      swap_r   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tgarle_pkg::REG_BYTES_PER_PIXEL: bpp_r    <= cfg_data[2:0];
        tgarle_pkg::REG_PIXEL_TOTAL:     total_r  <= cfg_data;
        tgarle_pkg::REG_PALETTE_EXPAND:  pal_en_r <= cfg_data[0];
        tgarle_pkg::REG_OUT_CHANNELS:    out_ch_r <= cfg_data[2:0];
        tgarle_pkg::REG_SWAP_RED_BLUE:   swap_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    priority if (pal_en_r)      width = 3'd1;
    else if (bpp_r == 3'd0)     width = 3'd1;
    else if (bpp_r > 3'd4)      width = 3'd4;
    else                        width = bpp_r;
  end

  always_comb begin
    if ((SUM_W'(total_r)) > (SUM_W'(1) << COUNT_BITS)) begin
      total_sat = SUM_W'(1) << COUNT_BITS;
    end else begin
      total_sat = SUM_W'(total_r);
    end
  end

  assign gather_new = gather_r | (32'(in_stream_byte) << {bip_r, 3'b000});
  assign count_c    = (phase_r == PH_LITERAL) ? 8'd1 : packet_left_r;
  assign sum        = SUM_W'(done_r) + SUM_W'(count_c);

  always_comb begin
    unique case (width)
      3'd1:    direct_val = gather_new & 32'h0000_00FF;
      3'd2:    direct_val = gather_new & 32'h0000_FFFF;
      3'd3:    direct_val = gather_new & 32'h00FF_FFFF;
      default: direct_val = gather_new;
    endcase
    if (swap_r && width >= 3'd3) begin
      direct_val = tgarle_pkg::swap02(direct_val);
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    packet_left_nxt = packet_left_r;
    bip_nxt         = bip_r;
    gather_nxt      = gather_r;
    done_nxt        = done_r;
    halted_nxt      = halted_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    emit            = 1'b0;
    res_value       = direct_val;
    res_count       = count_c;
    res_status      = tgarle_pkg::ST_PIXELS;
    res_pal         = 1'b0;
    res_oob         = ({1'b0, gather_new[7:0]} >= 9'(PALETTE_DEPTH));
    if (accept) begin
      unique case (tgarle_pkg::mode_t'(in_mode))
        tgarle_pkg::MODE_START: begin
          phase_nxt       = PH_HEADER;
          packet_left_nxt = 8'd0;
          bip_nxt         = 2'd0;
          gather_nxt      = 32'd0;
          done_nxt        = '0;
          halted_nxt      = 1'b0;
        end
        tgarle_pkg::MODE_STREAM: begin
          if (!halted_r) begin
            if (phase_r == PH_HEADER) begin
              if (in_stream_byte < tgarle_pkg::RUN_FLAG) begin
                packet_left_nxt = in_stream_byte + 8'd1;
                phase_nxt       = PH_LITERAL;
              end else begin
                packet_left_nxt = in_stream_byte - tgarle_pkg::RUN_OFFSET;
                phase_nxt       = PH_RUN;
              end
              bip_nxt    = 2'd0;
              gather_nxt = 32'd0;
            end else if ({1'b0, bip_r} + 3'd1 < width) begin
              bip_nxt    = bip_r + 2'd1;
              gather_nxt = gather_new;
            end else begin
              bip_nxt    = 2'd0;
              gather_nxt = 32'd0;
              if (phase_r == PH_LITERAL) begin
                packet_left_nxt = packet_left_r - 8'd1;
                if (packet_left_r == 8'd1) begin
                  phase_nxt = PH_HEADER;
                end
              end else begin
                packet_left_nxt = 8'd0;
                phase_nxt       = PH_HEADER;
              end
              emit          = 1'b1;
              out_valid_nxt = 1'b1;
              if (sum > total_sat) begin
                halted_nxt = 1'b1;
                res_value  = 32'd0;
                res_count  = 8'd0;
                res_status = tgarle_pkg::ST_OVERFLOW;
              end else begin
                done_nxt = sum[CNT_W-1:0];
                res_pal  = pal_en_r;
                if (sum == total_sat) begin
                  halted_nxt = 1'b1;
                  res_status = tgarle_pkg::ST_COMPLETE;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_HEADER;
      packet_left_r <= 8'd0;
      bip_r         <= 2'd0;
      gather_r      <= 32'd0;
      done_r        <= '0;
      halted_r      <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      packet_left_r <= packet_left_nxt;
      bip_r         <= bip_nxt;
      gather_r      <= gather_nxt;
      done_r        <= done_nxt;
      halted_r      <= halted_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      value_r     <= res_value;
      count_r     <= res_count;
      status_r    <= res_status;
      pal_sel_r   <= res_pal;
      pal_oob_r   <= res_oob;
      pal_keep4_r <= (out_ch_r >= 3'd4);
    end
  end

  // palette entries are stored with bytes 0 and 2 swapped
  assign ram_we = accept && (tgarle_pkg::mode_t'(in_mode) == tgarle_pkg::MODE_PALETTE) &&
                  ({1'b0, in_palette_index} < 9'(PALETTE_DEPTH));

  tgarle_ram #(
    .WIDTH (32),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_palette_index[AW-1:0]),
    .wdata (tgarle_pkg::swap02(in_palette_word)),
    .re    (emit && res_pal && !res_oob),
    .raddr (gather_new[AW-1:0]),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (!pal_sel_r) begin
      out_pixel_value = value_r;
    end else if (pal_oob_r) begin
      out_pixel_value = 32'd0;
    end else if (pal_keep4_r) begin
      out_pixel_value = ram_rdata;
    end else begin
      out_pixel_value = ram_rdata & 32'h00FF_FFFF;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_repeat_count = count_r;
  assign out_status       = status_r;

  `ASSERT_NEXT(a_halted_no_result, clk, rst_n,
    accept && halted_r && (in_mode == tgarle_pkg::MODE_STREAM), !out_valid_r,
    "stream byte produced a result while halted")
  `ASSERT_IMPLY(a_overflow_empty, clk, rst_n,
    out_valid_r && (status_r == tgarle_pkg::ST_OVERFLOW),
    (count_r == 8'd0) && (value_r == 32'd0),
    "overflow result carries pixel data")
  `ASSERT_IMPLY(a_end_halts, clk, rst_n,
    out_valid_r && (status_r != tgarle_pkg::ST_PIXELS), halted_r,
    "completion or overflow result without halt")
  `ASSERT_IMPLY(a_literal_left, clk, rst_n, phase_r == PH_LITERAL, packet_left_r != 8'd0,
    "literal packet with no pixels left")
  `ASSERT_IMPLY(a_pal_status, clk, rst_n, out_valid_r && pal_sel_r,
    status_r != tgarle_pkg::ST_OVERFLOW, "palette lookup on an overflow result")

endmodule

@@ verif/tb_tga_rle_pixel_decoder.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// TGA RLE pixel decoder testbench
// Sends packet streams, palette loads, image starts and ignored-mode requests under a
// series of register settings, predicts every pixel/run result in order and compares
// the result channel against that prediction field by field.
// ---------------------------------------------------------------------------
module tb_tga_rle_pixel_decoder;

  localparam int COUNT_BITS = 30;

  typedef struct {
    tgarle_pkg::mode_t mode;
    logic [7:0]        data;
    logic [7:0]        index;
    logic [31:0]       word;
    bit                drain;
  } request_t;

  typedef struct {
    logic [31:0]         value;
    logic [7:0]          count;
    tgarle_pkg::status_t status;
  } run_t;

  typedef enum logic [1:0] {WAIT_HEADER, LITERAL_BYTES, RUN_BYTES} parse_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [30:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = '0;
  logic [7:0]  in_stream_byte = '0;
  logic [7:0]  in_palette_index = '0;
  logic [31:0] in_palette_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_pixel_value;
  logic [7:0]  out_repeat_count;
  logic [1:0]  out_status;

  // register copies
  logic [2:0]  cfg_bpp = 3'd3;
  logic [30:0] cfg_total = 31'd1;
  bit          cfg_pal = 1'b0;
  logic [2:0]  cfg_och = 3'd3;
  bit          cfg_swap = 1'b0;

  // decoder state
  parse_t          dec_phase = WAIT_HEADER;
  int unsigned     dec_left = 0;
  int unsigned     dec_pos = 0;
  logic [31:0]     dec_gather = '0;
  longint unsigned dec_done = 0;
  bit              dec_halted = 1'b0;
  logic [31:0]     palette_mem [256];

  request_t    request_q[$];
  request_t    cur_req;
  run_t        expected_runs[$];
  run_t        head_run;
  int unsigned queued_cnt = 0;
  int unsigned taken_cnt = 0;
  int unsigned err_cnt = 0;
  int unsigned send_gap = 0;
  int unsigned recv_stall = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;
  bit          hold_ask = 1'b0;
  bit          hold_taken = 1'b0;

  // stimulus side view of the stream
  bit              gen_pal = 1'b0;
  int unsigned     gen_w = 3;
  longint unsigned gen_cap = 1;
  longint unsigned gen_pixels = 0;
  int unsigned     phase_items = 0;
  int unsigned     phase_limit = 0;
  int unsigned     pal_known[$];

  tga_rle_pixel_decoder #(
    .PALETTE_DEPTH(256),
    .COUNT_BITS   (COUNT_BITS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_stream_byte  (in_stream_byte),
    .in_palette_index(in_palette_index),
    .in_palette_word (in_palette_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_value (out_pixel_value),
    .out_repeat_count(out_repeat_count),
    .out_status      (out_status)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] rb_swap(input logic [31:0] v);
    logic [31:0] s;
    s = v;
    s[7:0]   = v[23:16];
    s[23:16] = v[7:0];
    return s;
  endfunction

  function automatic int unsigned stream_width(input bit pal, input logic [2:0] bpp);
    if (pal) return 1;
    if (bpp == 3'd0) return 1;
    if (bpp > 3'd4) return 4;
    return 32'(bpp);
  endfunction

  function automatic void decode_request(input request_t r);
    int unsigned     w;
    int unsigned     cnt;
    logic [31:0]     v;
    longint unsigned cap;
    run_t            res;
    case (r.mode)
      tgarle_pkg::MODE_START: begin
        dec_phase  = WAIT_HEADER;
        dec_left   = 0;
        dec_pos    = 0;
        dec_gather = '0;
        dec_done   = 0;
        dec_halted = 1'b0;
      end
      tgarle_pkg::MODE_PALETTE: palette_mem[r.index] = rb_swap(r.word);
      tgarle_pkg::MODE_STREAM: if (!dec_halted) begin
        if (dec_phase == WAIT_HEADER) begin
          if (r.data < tgarle_pkg::RUN_FLAG) begin
            dec_left  = r.data + 1;
            dec_phase = LITERAL_BYTES;
          end else begin
            dec_left  = r.data - tgarle_pkg::RUN_OFFSET;
            dec_phase = RUN_BYTES;
          end
          dec_pos    = 0;
          dec_gather = '0;
        end else begin
          w = stream_width(cfg_pal, cfg_bpp);
          dec_gather[8*dec_pos +: 8] = r.data;
          if (dec_pos + 1 < w) begin
            dec_pos++;
          end else begin
            if (cfg_pal) begin
              v = palette_mem[dec_gather[7:0]];
              if (cfg_och < 3'd4) v[31:24] = 8'h00;
            end else begin
              v = dec_gather;
              if (w < 4) v = v & ((32'h1 << (8*w)) - 32'h1);
              if (cfg_swap && w >= 3) v = rb_swap(v);
            end
            dec_pos    = 0;
            dec_gather = '0;
            if (dec_phase == LITERAL_BYTES) begin
              cnt = 1;
              dec_left--;
              if (dec_left == 0) dec_phase = WAIT_HEADER;
            end else begin
              cnt       = dec_left;
              dec_left  = 0;
              dec_phase = WAIT_HEADER;
            end
            cap = cfg_total;
            if (cap > (64'd1 << COUNT_BITS)) cap = 64'd1 << COUNT_BITS;
            if (dec_done + cnt > cap) begin
              dec_halted = 1'b1;
              res = '{32'h0, 8'h0, tgarle_pkg::ST_OVERFLOW};
            end else begin
              dec_done += cnt;
              res = '{v, 8'(cnt), tgarle_pkg::ST_PIXELS};
              if (dec_done == cap) begin
                dec_halted = 1'b1;
                res.status = tgarle_pkg::ST_COMPLETE;
              end
            end
            expected_runs.push_back(res);
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, 9);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        decode_request(cur_req);
        taken_cnt++;
        if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
        send_gap = draw_wait(send_quiet);
      end
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (request_q.size() != 0 &&
                     (!request_q[0].drain || expected_runs.size() == 0)) begin
          cur_req = request_q.pop_front();
          in_valid         <= 1'b1;
          in_mode          <= cur_req.mode;
          in_stream_byte   <= cur_req.data;
          in_palette_index <= cur_req.index;
          in_palette_word  <= cur_req.word;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_runs.size() == 0) begin
          $display("%0t: unexpected result: value %h count %0d status %0d",
                   $time, out_pixel_value, out_repeat_count, out_status);
          err_cnt++;
        end else begin
          head_run = expected_runs.pop_front();
          if (out_pixel_value !== head_run.value) begin
            $display("%0t: pixel_value expected %h got %h",
                     $time, head_run.value, out_pixel_value);
            err_cnt++;
          end
          if (out_repeat_count !== head_run.count) begin
            $display("%0t: repeat_count expected %0d got %0d",
                     $time, head_run.count, out_repeat_count);
            err_cnt++;
          end
          if (out_status !== head_run.status) begin
            $display("%0t: status expected %0d got %0d",
                     $time, head_run.status, out_status);
            err_cnt++;
          end
        end
        if ($urandom_range(0, 29) == 0) recv_quiet = !recv_quiet;
        recv_stall = draw_wait(recv_quiet);
      end
      // one long back-pressure window so the output register fills
      if (hold_ask && !hold_taken) begin
        hold_taken = 1'b1;
        recv_stall = 300;
      end
      if (recv_stall != 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  function automatic void push_req(input tgarle_pkg::mode_t m, input logic [7:0] d,
                                   input logic [7:0] idx, input logic [31:0] w,
                                   input bit drain);
    request_t r;
    r.mode  = m;
    r.data  = d;
    r.index = idx;
    r.word  = w;
    r.drain = drain;
    request_q.push_back(r);
    queued_cnt++;
    phase_items++;
  endfunction

  function automatic void push_byte(input logic [7:0] d);
    push_req(tgarle_pkg::MODE_STREAM, d, 8'($urandom), $urandom,
             $urandom_range(0, 39) == 0);
  endfunction

  function automatic void push_start(input bit drain);
    push_req(tgarle_pkg::MODE_START, 8'($urandom), 8'($urandom), $urandom, drain);
    gen_pixels = 0;
  endfunction

  function automatic void push_palette(input logic [7:0] idx, input logic [31:0] w);
    push_req(tgarle_pkg::MODE_PALETTE, 8'($urandom), idx, w, 1'b0);
    pal_known.push_back(idx);
  endfunction

  // index requests only name palette entries that were loaded
  function automatic void push_pixel();
    if (gen_pal)
      push_byte(8'(pal_known[$urandom_range(0, pal_known.size() - 1)]));
    else
      repeat (gen_w) push_byte(8'($urandom_range(0, 255)));
  endfunction

  // cut: packet ends early and a new image start follows
  function automatic void push_packet(input bit cut);
    int unsigned n;
    int unsigned k;
    if ($urandom_range(0, 1) == 1) begin
      n = $urandom_range(1, 4);
      if ($urandom_range(0, 19) == 0) begin
        k = $urandom_range(1, 128);
        // long literal packets only while the phase's item budget has room
        if (phase_items + k * gen_w + 1 <= phase_limit) n = k;
      end
      push_byte(8'(n - 1));
      k = cut ? $urandom_range(0, n - 1) : n;
      repeat (k) push_pixel();
    end else begin
      n = $urandom_range(1, 128);
      push_byte(8'(n + 127));
      if (!cut) push_pixel();
      else if (!gen_pal) repeat ($urandom_range(0, gen_w - 1)) push_byte(8'($urandom));
    end
    if (cut) begin
      push_start($urandom_range(0, 9) == 0);
    end else begin
      gen_pixels += n;
      if (gen_pixels >= gen_cap) push_start($urandom_range(0, 9) == 0);
    end
  endfunction

  task automatic settle();
    do @(posedge clk); while (taken_cnt != queued_cnt || expected_runs.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic load_settings(input logic [2:0] bpp, input logic [30:0] total,
                               input bit pal, input logic [2:0] och, input bit swap);
    logic [2:0]  idx [5];
    logic [30:0] val [5];
    idx = '{tgarle_pkg::REG_BYTES_PER_PIXEL, tgarle_pkg::REG_PIXEL_TOTAL,
            tgarle_pkg::REG_PALETTE_EXPAND, tgarle_pkg::REG_OUT_CHANNELS,
            tgarle_pkg::REG_SWAP_RED_BLUE};
    val = '{31'(bpp), total, 31'(pal), 31'(och), 31'(swap)};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
    end
    cfg_we    <= 1'b0;
    cfg_bpp   = bpp;
    cfg_total = total;
    cfg_pal   = pal;
    cfg_och   = och;
    cfg_swap  = swap;
    gen_pal   = pal;
    gen_w     = stream_width(pal, bpp);
    gen_cap   = (total > (64'd1 << COUNT_BITS)) ? (64'd1 << COUNT_BITS) : total;
  endtask

  task automatic random_phase(input logic [2:0] bpp, input logic [30:0] total,
                              input bit pal, input logic [2:0] och, input bit swap,
                              input int unsigned n, input bit hold);
    int unsigned pick;
    settle();
    load_settings(bpp, total, pal, och, swap);
    if (hold) hold_ask = 1'b1;
    phase_items = 0;
    phase_limit = n;
    push_start(1'b0);
    while (phase_items < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 68) push_packet(1'b0);
      else if (pick < 74) push_packet(1'b1);
      else if (pick < 80) push_start($urandom_range(0, 3) == 0);
      else if (pick < 85) push_req(tgarle_pkg::MODE_NONE, 8'($urandom), 8'($urandom),
                                   $urandom, 1'b0);
      else if (pick < 93) push_palette(8'($urandom_range(0, 255)), $urandom);
      else if (!pal) repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
      else push_packet(1'b0);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // literal and run pixels with red/blue swap, full-length run, ignored mode
    load_settings(3'd3, 31'd1000, 1'b0, 3'd3, 1'b1);
    push_start(1'b0);
    push_byte(8'h00);
    push_byte(8'h00); push_byte(8'hFF); push_byte(8'h80);
    push_req(tgarle_pkg::MODE_NONE, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 1'b0);
    push_byte(8'hFF);
    push_byte(8'hFF); push_byte(8'hFF); push_byte(8'hFF);
    push_byte(8'h80);
    push_byte(8'h12); push_byte(8'h34); push_byte(8'h56);

    // palette lookups, completion, bytes after halt, overflow on a run
    settle();
    load_settings(3'd3, 31'd2, 1'b1, 3'd4, 1'b1);
    push_palette(8'h00, 32'hFFFF_FFFF);
    push_palette(8'hFF, 32'h5A00_C3A5);
    push_start(1'b0);
    push_byte(8'h01);
    push_byte(8'hFF); push_byte(8'h00);
    push_byte(8'h55);
    push_start(1'b1);
    push_byte(8'h82);
    push_byte(8'h00);

    // zero pixel total: first pixel overflows
    settle();
    load_settings(3'd1, 31'd0, 1'b0, 3'd3, 1'b0);
    push_start(1'b0);
    push_byte(8'h80);
    push_byte(8'hAB);

    random_phase(3'd4, 31'h7FFF_FFFF, 1'b0, 3'd7, 1'b1, 70, 1'b0);
    random_phase(3'd1, 31'($urandom_range(30, 150)), 1'b0, 3'd3, 1'b0, 80, 1'b1);
    random_phase(3'd2, 31'($urandom_range(10, 80)), 1'b0, 3'd4, 1'b1, 60, 1'b0);
    random_phase(3'd0, 31'($urandom_range(5, 40)), 1'b0, 3'd0, 1'b1, 55, 1'b0);
    random_phase(3'd7, 31'd1, 1'b0, 3'd3, 1'b1, 45, 1'b0);
    random_phase(3'd3, 31'($urandom_range(20, 100)), 1'b1, 3'd3, 1'b1, 75, 1'b0);
    random_phase(3'd5, 31'h4000_0000, 1'b1, 3'd0, 1'b0, 65, 1'b0);
    random_phase(3'd1, 31'd1, 1'b1, 3'd4, 1'b0, 35, 1'b0);
    random_phase(3'd3, 31'($urandom_range(5, 60)), 1'b0, 3'd3,
                 $urandom_range(0, 1) == 1, 65, 1'b0);
    random_phase(3'd6, 31'($urandom_range(10, 90)), 1'b0, 3'd5, 1'b0, 45, 1'b0);

    settle();
    repeat (6) @(posedge clk);
    if (err_cnt == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #1_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
